// ===== src/lnr_pkg.sv =====
// Shared constants for the layer-norm row block.
package lnr_pkg;

    // Storage depth default and item field widths
    localparam int MAX_FEATURES_DEF = 64;
    localparam int VAL_W            = 16;
    localparam int ENTRY_W          = 3 * VAL_W;
    localparam int N_W              = 7;

    // Configuration port
    localparam int CFG_AW      = 3;
    localparam int CFG_DW      = 32;
    localparam int EPS_W       = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;
    localparam logic REG_EPSILON = 1'b0;

    // Datapath widths, sized for at most 64 features
    localparam int SUM_W = 24;
    localparam int D_W   = 24;
    localparam int S2_W  = 51;
    localparam int MUL_W = 32;
    localparam int QUO_W = 64;
    localparam int DEN_W = 34;
    localparam int INV_W = 29;
    localparam int P_W   = 22;

endpackage

// ===== src/layer_norm_row.sv =====
// Layer normalization of one row of Q8.8 features, top level.
//
// Input stream (s_*): one item per feature, tdata = {offset, gain, feature_value},
// tlast closes the row. While a row is loading, one item is taken per cycle.
// After the closing item s_tready drops until the last result of the row has
// been moved into the output register.
// Output stream (m_*): one item per stored feature in arrival order; tdata holds
// the normalized value, tlast marks the last result, tuser = {row_truncated, clipped}.
// Row processing after the closing item: a 64-step restoring divider runs twice
// per row (variance, reciprocal) and once per result (rounded scaling); a 32-step
// square root and a shared 32x32 multiplier with a 64-bit subtractor do the rest.
// Results leave through an output register: the sequencer computes the next
// result while the current one waits, and holds when the receiver stalls.
// Features beyond MAX_FEATURES are dropped and flagged on every result of the row.
// Reset (aresetn low, synchronous) empties the row and sets epsilon to 1.
// APB port: epsilon at byte address 0; user must write only while idle, not enforced.
module layer_norm_row #(
    parameter int MAX_FEATURES = lnr_pkg::MAX_FEATURES_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [15:0] feature_value, [31:16] gain, [47:32] offset
    input  logic [lnr_pkg::ENTRY_W-1:0] s_tdata,
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [15:0] normalized_value
    output logic [lnr_pkg::VAL_W-1:0]   m_tdata,
    output logic                        m_tlast,
    // [0] clipped, [1] row_truncated
    output logic [1:0]                  m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lnr_pkg::CFG_AW-1:0]  paddr,
    input  logic [lnr_pkg::CFG_DW-1:0]  pwdata,
    output logic [lnr_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int AW = $clog2(MAX_FEATURES);
    localparam int CW = $clog2(MAX_FEATURES + 1);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_N3A   = 5'd1;
    localparam logic [4:0] ST_N3B   = 5'd2;
    localparam logic [4:0] ST_N3C   = 5'd3;
    localparam logic [4:0] ST_VRD   = 5'd4;
    localparam logic [4:0] ST_VD    = 5'd5;
    localparam logic [4:0] ST_VSQ   = 5'd6;
    localparam logic [4:0] ST_VACC  = 5'd7;
    localparam logic [4:0] ST_DVAR  = 5'd8;
    localparam logic [4:0] ST_VDONE = 5'd9;
    localparam logic [4:0] ST_IDONE = 5'd10;
    localparam logic [4:0] ST_SQRT  = 5'd11;
    localparam logic [4:0] ST_DIV   = 5'd12;
    localparam logic [4:0] ST_ORD   = 5'd13;
    localparam logic [4:0] ST_OD    = 5'd14;
    localparam logic [4:0] ST_OM1   = 5'd15;
    localparam logic [4:0] ST_OM2   = 5'd16;
    localparam logic [4:0] ST_OZ    = 5'd17;
    localparam logic [4:0] ST_OP    = 5'd18;

    logic [4:0]                        state_reg;
    logic [4:0]                        ret_reg;
    logic [CW-1:0]                     count_reg;
    logic [CW-1:0]                     idx_reg;
    logic signed [lnr_pkg::SUM_W-1:0]  sum_reg;
    logic                              ovf_reg;
    logic [lnr_pkg::EPS_W-1:0]         eps_reg;

    logic signed [lnr_pkg::D_W-1:0]    d_reg;
    logic signed [lnr_pkg::VAL_W-1:0]  g_reg;
    logic signed [lnr_pkg::VAL_W-1:0]  b_reg;
    logic [lnr_pkg::S2_W-1:0]          s2_reg;
    logic [18:0]                       n3_reg;
    logic [lnr_pkg::INV_W-1:0]         inv_reg;
    logic [2*lnr_pkg::MUL_W-1:0]       mul_p_reg;

    logic [lnr_pkg::QUO_W-1:0]         dq_reg;
    logic [lnr_pkg::DEN_W-1:0]         den_reg;
    logic [lnr_pkg::DEN_W-1:0]         rem_reg;
    logic [5:0]                        step_reg;
    logic [63:0]                       sq_a_reg;
    logic [63:0]                       sq_r_reg;
    logic [63:0]                       sq_bit_reg;

    logic                              m_valid_reg;
    logic [lnr_pkg::VAL_W-1:0]         out_val_reg;
    logic                              out_last_reg;
    logic                              out_clip_reg;
    logic                              out_trunc_reg;

    logic                              in_acc;
    logic                              cfg_wr;
    logic                              store_wr;
    logic [lnr_pkg::ENTRY_W-1:0]       ram_rdata;
    logic [lnr_pkg::N_W-1:0]           n_w;
    logic signed [lnr_pkg::VAL_W-1:0]  x_in;
    logic signed [lnr_pkg::VAL_W-1:0]  x_rd;
    logic signed [lnr_pkg::D_W-1:0]    nx;
    logic signed [lnr_pkg::D_W:0]      d_calc;
    logic [lnr_pkg::D_W-2:0]           d_mag;
    logic [lnr_pkg::VAL_W-1:0]         g_mag;
    logic [CW-1:0]                     idx_inc;
    logic                              idx_end;

    logic                              mul_en;
    logic [lnr_pkg::MUL_W-1:0]         mul_a;
    logic [lnr_pkg::MUL_W-1:0]         mul_b;

    logic [63:0]                       sub_a;
    logic [63:0]                       sub_b;
    logic [64:0]                       sub_d;
    logic                              sub_ge;
    logic [lnr_pkg::DEN_W:0]           rem_sh;
    logic [63:0]                       sq_r_next;
    logic [lnr_pkg::DEN_W-1:0]         v_sum;

    logic                              out_free;
    logic [63:0]                       p_rnd;
    logic [lnr_pkg::P_W-2:0]           p_mag;
    logic                              p_neg;
    logic signed [lnr_pkg::P_W-1:0]    p_s;
    logic signed [lnr_pkg::P_W-1:0]    r_s;
    logic [lnr_pkg::VAL_W-1:0]         r_sat;
    logic                              r_clip;

    // handshakes
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == lnr_pkg::REG_EPSILON)
                      ? lnr_pkg::CFG_DW'(eps_reg) : '0;
    assign store_wr = in_acc && (count_reg < CW'(MAX_FEATURES));

    // row store
    lnr_ram #(
        .WIDTH (lnr_pkg::ENTRY_W),
        .DEPTH (MAX_FEATURES)
    ) u_store (
        .clk     (aclk),
        .wr_en   (store_wr),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ram_rdata)
    );

    // deviation scaled by n: d = n*x - sum
    assign n_w    = lnr_pkg::N_W'(count_reg);
    assign x_in   = $signed(s_tdata[lnr_pkg::VAL_W-1:0]);
    assign x_rd   = $signed(ram_rdata[lnr_pkg::VAL_W-1:0]);
    assign nx     = $signed({1'b0, n_w}) * x_rd;
    assign d_calc = (lnr_pkg::D_W+1)'(nx) - (lnr_pkg::D_W+1)'(sum_reg);
    assign d_mag  = d_reg[lnr_pkg::D_W-1] ? (lnr_pkg::D_W-1)'(-d_reg)
                                          : (lnr_pkg::D_W-1)'(d_reg);
    assign g_mag  = g_reg[lnr_pkg::VAL_W-1] ? lnr_pkg::VAL_W'(-g_reg)
                                            : lnr_pkg::VAL_W'(g_reg);
    assign idx_inc = idx_reg + CW'(1);
    assign idx_end = (idx_inc == count_reg);

    // shared multiplier operand select
    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        unique case (state_reg)
            ST_N3A: begin
                mul_a = lnr_pkg::MUL_W'(n_w);
                mul_b = lnr_pkg::MUL_W'(n_w);
            end
            ST_N3B: begin
                mul_a = mul_p_reg[lnr_pkg::MUL_W-1:0];
                mul_b = lnr_pkg::MUL_W'(n_w);
            end
            ST_VSQ: begin
                mul_a = lnr_pkg::MUL_W'(d_mag);
                mul_b = lnr_pkg::MUL_W'(d_mag);
            end
            ST_OM1: begin
                mul_a = lnr_pkg::MUL_W'(d_mag);
                mul_b = lnr_pkg::MUL_W'(inv_reg);
            end
            ST_OZ: begin
                mul_a = dq_reg[lnr_pkg::MUL_W-1:0];
                mul_b = lnr_pkg::MUL_W'(g_mag);
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // shared 64-bit subtract/compare for divider and square root
    assign rem_sh = {rem_reg, dq_reg[lnr_pkg::QUO_W-1]};
    always_comb begin
        if (state_reg == ST_SQRT) begin
            sub_a = sq_a_reg;
            sub_b = sq_r_reg | sq_bit_reg;
        end else begin
            sub_a = 64'(rem_sh);
            sub_b = 64'(den_reg);
        end
    end
    assign sub_d     = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_ge    = !sub_d[64];
    assign sq_r_next = sub_ge ? ((sq_r_reg >> 1) | sq_bit_reg) : (sq_r_reg >> 1);
    assign v_sum     = lnr_pkg::DEN_W'(dq_reg[32:0]) + lnr_pkg::DEN_W'(eps_reg);

    // final rounding, offset and saturation
    assign out_free = !m_valid_reg || m_tready;
    assign p_rnd    = mul_p_reg + 64'h8000;
    assign p_mag    = p_rnd[lnr_pkg::P_W+14:16];
    assign p_neg    = d_reg[lnr_pkg::D_W-1] ^ g_reg[lnr_pkg::VAL_W-1];
    assign p_s      = p_neg ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
    assign r_s      = p_s + lnr_pkg::P_W'(b_reg);
    always_comb begin
        r_clip = 1'b1;
        if (r_s > lnr_pkg::P_W'(32767)) begin
            r_sat = 16'h7FFF;
        end else if (r_s < -lnr_pkg::P_W'(32768)) begin
            r_sat = 16'h8000;
        end else begin
            r_sat  = r_s[lnr_pkg::VAL_W-1:0];
            r_clip = 1'b0;
        end
    end

    // sequencer and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            sum_reg     <= '0;
            ovf_reg     <= 1'b0;
            eps_reg     <= lnr_pkg::EPS_RESET;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr && (paddr[2] == lnr_pkg::REG_EPSILON)) begin
                eps_reg <= pwdata[lnr_pkg::EPS_W-1:0];
            end
            // output valid: set on a new result, cleared when taken
            if ((state_reg == ST_OP) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (store_wr) begin
                            count_reg <= count_reg + CW'(1);
                            sum_reg   <= sum_reg + lnr_pkg::SUM_W'(x_in);
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_tlast) begin
                            state_reg <= ST_N3A;
                        end
                    end
                end
                ST_N3A:  state_reg <= ST_N3B;
                ST_N3B:  state_reg <= ST_N3C;
                ST_N3C: begin
                    idx_reg   <= '0;
                    state_reg <= ST_VRD;
                end
                ST_VRD:  state_reg <= ST_VD;
                ST_VD:   state_reg <= ST_VSQ;
                ST_VSQ:  state_reg <= ST_VACC;
                ST_VACC: begin
                    idx_reg   <= idx_inc;
                    state_reg <= idx_end ? ST_DVAR : ST_VRD;
                end
                ST_DVAR: begin
                    step_reg  <= '0;
                    ret_reg   <= ST_VDONE;
                    state_reg <= ST_DIV;
                end
                ST_VDONE: begin
                    step_reg  <= '0;
                    ret_reg   <= ST_IDONE;
                    state_reg <= ST_DIV;
                end
                ST_IDONE: begin
                    step_reg  <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd31) begin
                        idx_reg   <= '0;
                        state_reg <= ST_ORD;
                    end
                end
                ST_DIV: begin
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'd63) begin
                        state_reg <= ret_reg;
                    end
                end
                ST_ORD:  state_reg <= ST_OD;
                ST_OD:   state_reg <= ST_OM1;
                ST_OM1:  state_reg <= ST_OM2;
                ST_OM2: begin
                    step_reg  <= '0;
                    ret_reg   <= ST_OZ;
                    state_reg <= ST_DIV;
                end
                ST_OZ:   state_reg <= ST_OP;
                ST_OP: begin
                    if (out_free) begin
                        idx_reg     <= idx_inc;
                        if (idx_end) begin
                            count_reg <= '0;
                            sum_reg   <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end else begin
                            state_reg <= ST_ORD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (mul_en) begin
            mul_p_reg <= mul_a * mul_b;
        end
        unique case (state_reg)
            ST_N3A:  s2_reg <= '0;
            ST_N3C:  n3_reg <= mul_p_reg[18:0];
            ST_VD:   d_reg  <= d_calc[lnr_pkg::D_W-1:0];
            ST_VACC: s2_reg <= s2_reg + lnr_pkg::S2_W'(mul_p_reg);
            ST_DVAR: begin
                dq_reg  <= lnr_pkg::QUO_W'(s2_reg);
                den_reg <= lnr_pkg::DEN_W'(n3_reg);
                rem_reg <= '0;
            end
            ST_VDONE: begin
                // zero variance plus epsilon counts as one
                dq_reg  <= 64'h0100_0000_0000_0000;
                den_reg <= (v_sum == '0) ? lnr_pkg::DEN_W'(1) : v_sum;
                rem_reg <= '0;
            end
            ST_IDONE: begin
                sq_a_reg   <= dq_reg;
                sq_r_reg   <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
            end
            ST_SQRT: begin
                if (sub_ge) begin
                    sq_a_reg <= sub_d[63:0];
                end
                sq_r_reg   <= sq_r_next;
                sq_bit_reg <= sq_bit_reg >> 2;
                if (step_reg == 6'd31) begin
                    inv_reg <= sq_r_next[lnr_pkg::INV_W-1:0];
                end
            end
            ST_DIV: begin
                // one restoring step per cycle
                rem_reg <= sub_ge ? sub_d[lnr_pkg::DEN_W-1:0]
                                  : rem_sh[lnr_pkg::DEN_W-1:0];
                dq_reg  <= {dq_reg[lnr_pkg::QUO_W-2:0], sub_ge};
            end
            ST_OD: begin
                d_reg <= d_calc[lnr_pkg::D_W-1:0];
                g_reg <= $signed(ram_rdata[2*lnr_pkg::VAL_W-1:lnr_pkg::VAL_W]);
                b_reg <= $signed(ram_rdata[3*lnr_pkg::VAL_W-1:2*lnr_pkg::VAL_W]);
            end
            ST_OM2: begin
                // add half the divisor for round-to-nearest
                dq_reg  <= mul_p_reg + 64'({n_w, 11'b0});
                den_reg <= lnr_pkg::DEN_W'({n_w, 12'b0});
                rem_reg <= '0;
            end
            ST_OP: begin
                if (out_free) begin
                    out_val_reg   <= r_sat;
                    out_clip_reg  <= r_clip;
                    out_last_reg  <= idx_end;
                    out_trunc_reg <= ovf_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_trunc_reg, out_clip_reg};

endmodule

// ===== src/lnr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lnr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/lnr_chk.sv =====
// Port-level checker for the layer-norm row block, bound to the top level.
module lnr_chk (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tlast,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [lnr_pkg::VAL_W-1:0]   m_tdata,
    input logic                        m_tlast
);

    // block is empty and ready right after reset
    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("not ready or output valid after reset");

    // a closing item starts row processing
    a_row_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("still ready after row end");

    // a non-closing item keeps the block loading
    a_row_load: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
        else $error("dropped ready in mid row");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

endmodule

bind layer_norm_row lnr_chk u_lnr_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
